// ===== rtl/wmsc_pkg.sv =====
// ----------------------------------------------------------------------------
// wmsc_pkg: shared definitions for the wiper mode and sweep controller
// Field widths, mode and phase codes, register indexes, servo and lamp
// timing constants, and the sweep status record.
// ----------------------------------------------------------------------------
package wmsc_pkg;

    // Field widths.
    localparam int SAMPLE_W   = 12;
    localparam int PAUSE_W    = 14;
    localparam int MODE_W     = 2;
    localparam int PHASE_W    = 2;
    localparam int DUTY_W     = 12;
    localparam int DWELL_W    = 14;
    localparam int BLINK_W    = 10;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 14;

    // Default depth of the moving average window.
    localparam int WINDOW_DEF = 8;

    // Milliseconds that pass with every tick.
    localparam int TICK_MS = 10;

    // Wiper modes.
    localparam logic [MODE_W-1:0] MODE_STOP     = 2'd0;
    localparam logic [MODE_W-1:0] MODE_INTERVAL = 2'd1;
    localparam logic [MODE_W-1:0] MODE_SLOW     = 2'd2;
    localparam logic [MODE_W-1:0] MODE_FAST     = 2'd3;

    // Sweep phases.
    localparam logic [PHASE_W-1:0] PHASE_IDLE = 2'd0;
    localparam logic [PHASE_W-1:0] PHASE_UP   = 2'd1;
    localparam logic [PHASE_W-1:0] PHASE_DOWN = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_THRESH_OFF_INTERVAL = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESH_INTERVAL_LOW = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESH_LOW_HIGH     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_MIN_SAFE     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_MAX_SAFE     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_JUMP            = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL_PAUSE_MS   = 3'd6;

    // Configuration reset values.
    localparam logic [SAMPLE_W-1:0] RST_THRESH_OFF_INTERVAL = 12'd500;
    localparam logic [SAMPLE_W-1:0] RST_THRESH_INTERVAL_LOW = 12'd2000;
    localparam logic [SAMPLE_W-1:0] RST_THRESH_LOW_HIGH     = 12'd3500;
    localparam logic [SAMPLE_W-1:0] RST_SAMPLE_MIN_SAFE     = 12'd50;
    localparam logic [SAMPLE_W-1:0] RST_SAMPLE_MAX_SAFE     = 12'd4040;
    localparam logic [SAMPLE_W-1:0] RST_MAX_JUMP            = 12'd1500;
    localparam logic [PAUSE_W-1:0]  RST_INTERVAL_PAUSE_MS   = 14'd3000;

    // Servo positions.
    localparam logic [DUTY_W-1:0] DUTY_PARK = 12'd800;
    localparam logic [DUTY_W-1:0] DUTY_FULL = 12'd3300;

    // Sweep times per mode, milliseconds.
    localparam logic [DWELL_W-1:0] SWEEP_MS_INTERVAL = 14'd500;
    localparam logic [DWELL_W-1:0] SWEEP_MS_LOW      = 14'd800;
    localparam logic [DWELL_W-1:0] SWEEP_MS_HIGH     = 14'd300;
    localparam logic [DWELL_W-1:0] DWELL_MAX         = 14'd16383;

    // Fault blink: 1 s period, lit for the first half.
    localparam int BLINK_PERIOD = 1000;
    localparam logic [BLINK_W-1:0] BLINK_ON = 10'd500;

    // Sweep state after one tick.
    typedef struct packed {
        logic [PHASE_W-1:0] phase;
        logic [DUTY_W-1:0]  duty;
    } sweep_status_t;

endpackage

// ===== rtl/wmsc_filter.sv =====
// ----------------------------------------------------------------------------
// wmsc_filter: moving average over the last WINDOW healthy samples
// Keeps the sample history in a small memory, a running sum and the held
// average. The oldest entry is read ahead into a register.
// ----------------------------------------------------------------------------
module wmsc_filter #(
    parameter int WINDOW = wmsc_pkg::WINDOW_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          update,
    input  logic [wmsc_pkg::SAMPLE_W-1:0] sample,
    output logic [wmsc_pkg::SAMPLE_W-1:0] level
);

    localparam int SLOT_W    = $clog2(WINDOW);
    localparam int SUM_W     = wmsc_pkg::SAMPLE_W + $clog2(WINDOW);
    localparam int DIV_SHIFT = SUM_W + $clog2(WINDOW);
    localparam int MULT_W    = SUM_W + 1;
    localparam int PROD_W    = SUM_W + MULT_W;
    localparam longint unsigned DIV_MULT_L =
        ((64'd1 << DIV_SHIFT) + 64'(WINDOW) - 64'd1) / 64'(WINDOW);
    localparam logic [MULT_W-1:0] DIV_MULT  = MULT_W'(DIV_MULT_L);
    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(WINDOW - 1);

    logic [wmsc_pkg::SAMPLE_W-1:0] hist_mem [WINDOW];
    logic [wmsc_pkg::SAMPLE_W-1:0] old_data_reg;
    logic [SLOT_W-1:0]             slot_reg;
    logic [SLOT_W-1:0]             slot_next;
    logic [SLOT_W-1:0]             rd_addr;
    logic                          wrapped_reg;
    logic [SUM_W-1:0]              sum_reg;
    logic [SUM_W-1:0]              sum_next;
    logic [wmsc_pkg::SAMPLE_W-1:0] avg_reg;
    logic [wmsc_pkg::SAMPLE_W-1:0] avg_next;
    logic [wmsc_pkg::SAMPLE_W-1:0] oldest;
    logic [PROD_W-1:0]             product;

    // Until the write slot has gone round once, the entry under it was never
    // written and counts as zero.
    assign oldest    = wrapped_reg ? old_data_reg : '0;
    assign slot_next = (slot_reg == SLOT_LAST) ? '0 : slot_reg + SLOT_W'(1);
    assign rd_addr   = update ? slot_next : slot_reg;

    assign sum_next = sum_reg - SUM_W'(oldest) + SUM_W'(sample);

    // Division by the window depth as a multiplication by its reciprocal.
    assign product  = PROD_W'(sum_next) * PROD_W'(DIV_MULT);
    assign avg_next = product[DIV_SHIFT +: wmsc_pkg::SAMPLE_W];

    assign level = update ? avg_next : avg_reg;

    always_ff @(posedge clk)
    begin
        if (update)
        begin
            hist_mem[slot_reg] <= sample;
        end
        old_data_reg <= hist_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg    <= '0;
            wrapped_reg <= 1'b0;
            sum_reg     <= '0;
            avg_reg     <= '0;
        end
        else if (update)
        begin
            slot_reg <= slot_next;
            sum_reg  <= sum_next;
            avg_reg  <= avg_next;
            if (slot_reg == SLOT_LAST)
            begin
                wrapped_reg <= 1'b1;
            end
        end
    end

endmodule

// ===== rtl/wmsc_sweep.sv =====
// ----------------------------------------------------------------------------
// wmsc_sweep: servo sweep sequencer
// Idle, up and down phases with a dwell counter in milliseconds and an
// extra pause in the down phase while in interval mode.
// ----------------------------------------------------------------------------
module wmsc_sweep (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         step,
    input  logic [wmsc_pkg::MODE_W-1:0]  mode,
    input  logic [wmsc_pkg::PAUSE_W-1:0] pause_ms,
    output wmsc_pkg::sweep_status_t      status_next
);

    localparam int WIDE_W = wmsc_pkg::DWELL_W + 1;

    logic [wmsc_pkg::PHASE_W-1:0] phase_reg;
    logic [wmsc_pkg::PHASE_W-1:0] phase_next;
    logic [wmsc_pkg::DWELL_W-1:0] dwell_reg;
    logic [wmsc_pkg::DWELL_W-1:0] dwell_next;
    logic [wmsc_pkg::DUTY_W-1:0]  duty_reg;
    logic [wmsc_pkg::DUTY_W-1:0]  duty_next;
    logic [wmsc_pkg::DWELL_W-1:0] sweep_ms;
    logic [wmsc_pkg::DWELL_W-1:0] dwell_inc;
    logic [wmsc_pkg::DWELL_W-1:0] target_ms;
    logic [WIDE_W-1:0]            dwell_sum;
    logic [WIDE_W-1:0]            target_sum;

    always_comb
    begin
        case (mode)
            wmsc_pkg::MODE_INTERVAL: sweep_ms = wmsc_pkg::SWEEP_MS_INTERVAL;
            wmsc_pkg::MODE_SLOW:     sweep_ms = wmsc_pkg::SWEEP_MS_LOW;
            default:                 sweep_ms = wmsc_pkg::SWEEP_MS_HIGH;
        endcase
    end

    // Entering the up phase clears the dwell before this tick is counted.
    assign dwell_sum = ((phase_reg == wmsc_pkg::PHASE_IDLE) ? '0 : WIDE_W'(dwell_reg))
                     + WIDE_W'(wmsc_pkg::TICK_MS);
    assign dwell_inc = (dwell_sum > WIDE_W'(wmsc_pkg::DWELL_MAX))
                     ? wmsc_pkg::DWELL_MAX : dwell_sum[wmsc_pkg::DWELL_W-1:0];

    assign target_sum = WIDE_W'(sweep_ms)
                      + ((mode == wmsc_pkg::MODE_INTERVAL) ? WIDE_W'(pause_ms) : '0);
    assign target_ms  = (target_sum > WIDE_W'(wmsc_pkg::DWELL_MAX))
                      ? wmsc_pkg::DWELL_MAX : target_sum[wmsc_pkg::DWELL_W-1:0];

    always_comb
    begin
        phase_next = phase_reg;
        dwell_next = dwell_inc;
        duty_next  = duty_reg;
        if (mode == wmsc_pkg::MODE_STOP)
        begin
            phase_next = wmsc_pkg::PHASE_IDLE;
            dwell_next = '0;
            duty_next  = wmsc_pkg::DUTY_PARK;
        end
        else
        begin
            case (phase_reg)
                wmsc_pkg::PHASE_IDLE,
                wmsc_pkg::PHASE_UP:
                begin
                    phase_next = wmsc_pkg::PHASE_UP;
                    duty_next  = wmsc_pkg::DUTY_FULL;
                    if (dwell_inc >= sweep_ms)
                    begin
                        phase_next = wmsc_pkg::PHASE_DOWN;
                        dwell_next = '0;
                        duty_next  = wmsc_pkg::DUTY_PARK;
                    end
                end
                wmsc_pkg::PHASE_DOWN:
                begin
                    if (dwell_inc >= target_ms)
                    begin
                        phase_next = wmsc_pkg::PHASE_IDLE;
                        dwell_next = '0;
                    end
                end
                default:
                begin
                    phase_next = wmsc_pkg::PHASE_IDLE;
                end
            endcase
        end
    end

    assign status_next.phase = phase_next;
    assign status_next.duty  = duty_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= wmsc_pkg::PHASE_IDLE;
            dwell_reg <= '0;
            duty_reg  <= wmsc_pkg::DUTY_PARK;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            dwell_reg <= dwell_next;
            duty_reg  <= duty_next;
        end
    end

endmodule

// ===== rtl/wiper_mode_and_sweep_controller.sv =====
// A result is presented after its input passes through the input register, then the result
// register. Throughput: one item per cycle while results are taken; the tick state is updated
// on the cycle that the item moves from the input register into the result register, so the
// next item sees it at once.
// Reset clears all control state and the tick state, and loads the registers' default values.
// Configuration writes are taken in every cycle; there is no clearing pass after reset.
// ----------------------------------------------------------------------------
// wiper_mode_and_sweep_controller: wiper mode selection and servo sweep
// Checks each tick's sensor sample for range and jump faults, filters it
// with a moving average, picks the wiper mode, drives the servo sweep and
// the status lamps.
// ----------------------------------------------------------------------------
module wiper_mode_and_sweep_controller #(
    parameter int WINDOW = wmsc_pkg::WINDOW_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,

    // Configuration write channel.
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [wmsc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [wmsc_pkg::CFG_DATA_W-1:0] cfg_data,

    // Tick input channel.
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [wmsc_pkg::SAMPLE_W-1:0]   adc_sample,
    input  logic                            bus_fault,
    input  logic                            remote_control,
    input  logic [wmsc_pkg::MODE_W-1:0]     remote_mode,

    // Result channel.
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [wmsc_pkg::DUTY_W-1:0]     servo_duty,
    output logic [wmsc_pkg::SAMPLE_W-1:0]   filtered_level,
    output logic [wmsc_pkg::MODE_W-1:0]     wiper_mode,
    output logic [wmsc_pkg::PHASE_W-1:0]    sweep_phase,
    output logic                            fault,
    output logic                            led_red,
    output logic                            led_green,
    output logic                            led_blue
);

    localparam int SW = wmsc_pkg::SAMPLE_W;

    // Configuration registers.
    logic [SW-1:0]                thresh_off_interval_reg;
    logic [SW-1:0]                thresh_interval_low_reg;
    logic [SW-1:0]                thresh_low_high_reg;
    logic [SW-1:0]                sample_min_safe_reg;
    logic [SW-1:0]                sample_max_safe_reg;
    logic [SW-1:0]                max_jump_reg;
    logic [wmsc_pkg::PAUSE_W-1:0] interval_pause_ms_reg;

    // Input register.
    logic                         s1_valid_reg;
    logic [SW-1:0]                s1_sample_reg;
    logic                         s1_bus_reg;
    logic                         s1_remote_reg;
    logic [wmsc_pkg::MODE_W-1:0]  s1_rmode_reg;

    // Tick state held in this module.
    logic [SW-1:0]                prev_sample_reg;
    logic [wmsc_pkg::BLINK_W-1:0] blink_reg;
    logic [wmsc_pkg::BLINK_W-1:0] blink_next;
    logic [wmsc_pkg::BLINK_W:0]   blink_sum;

    // Result register.
    logic                          out_valid_reg;
    logic [wmsc_pkg::DUTY_W-1:0]   duty_out_reg;
    logic [SW-1:0]                 level_out_reg;
    logic [wmsc_pkg::MODE_W-1:0]   mode_out_reg;
    logic [wmsc_pkg::PHASE_W-1:0]  phase_out_reg;
    logic                          fault_out_reg;
    logic                          red_out_reg;
    logic                          green_out_reg;
    logic                          blue_out_reg;

    // Per-tick logic.
    logic                          advance;
    logic                          update;
    logic                          healthy;
    logic                          stable;
    logic                          fault_now;
    logic [SW-1:0]                 delta;
    logic [SW-1:0]                 level;
    logic [wmsc_pkg::MODE_W-1:0]   mode_now;
    logic                          red_now;
    logic                          green_now;
    logic                          blue_now;
    wmsc_pkg::sweep_status_t       sweep_next;

    // ------------------------------------------------------------------
    // Handshake. The input register moves into the result register
    // whenever the result register is empty or its transfer completes in
    // this cycle, so a waiting result lets the input side take only the
    // one item that the input register holds before it stops.
    // ------------------------------------------------------------------
    assign advance   = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !s1_valid_reg || advance;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            s1_sample_reg <= adc_sample;
            s1_bus_reg    <= bus_fault;
            s1_remote_reg <= remote_control;
            s1_rmode_reg  <= remote_mode;
        end
    end

    // ------------------------------------------------------------------
    // Configuration registers. Writes to an index past the list are
    // dropped. The 12-bit registers keep the low bits of the data.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thresh_off_interval_reg <= wmsc_pkg::RST_THRESH_OFF_INTERVAL;
            thresh_interval_low_reg <= wmsc_pkg::RST_THRESH_INTERVAL_LOW;
            thresh_low_high_reg     <= wmsc_pkg::RST_THRESH_LOW_HIGH;
            sample_min_safe_reg     <= wmsc_pkg::RST_SAMPLE_MIN_SAFE;
            sample_max_safe_reg     <= wmsc_pkg::RST_SAMPLE_MAX_SAFE;
            max_jump_reg            <= wmsc_pkg::RST_MAX_JUMP;
            interval_pause_ms_reg   <= wmsc_pkg::RST_INTERVAL_PAUSE_MS;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                wmsc_pkg::CFG_THRESH_OFF_INTERVAL: thresh_off_interval_reg <= cfg_data[SW-1:0];
                wmsc_pkg::CFG_THRESH_INTERVAL_LOW: thresh_interval_low_reg <= cfg_data[SW-1:0];
                wmsc_pkg::CFG_THRESH_LOW_HIGH:     thresh_low_high_reg     <= cfg_data[SW-1:0];
                wmsc_pkg::CFG_SAMPLE_MIN_SAFE:     sample_min_safe_reg     <= cfg_data[SW-1:0];
                wmsc_pkg::CFG_SAMPLE_MAX_SAFE:     sample_max_safe_reg     <= cfg_data[SW-1:0];
                wmsc_pkg::CFG_MAX_JUMP:            max_jump_reg            <= cfg_data[SW-1:0];
                wmsc_pkg::CFG_INTERVAL_PAUSE_MS:   interval_pause_ms_reg   <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Blink phase. It advances first on every tick and wraps at one
    // second; one subtraction is enough since a tick is shorter than that.
    // ------------------------------------------------------------------
    assign blink_sum  = (wmsc_pkg::BLINK_W + 1)'(blink_reg)
                      + (wmsc_pkg::BLINK_W + 1)'(wmsc_pkg::TICK_MS);
    assign blink_next = (blink_sum >= (wmsc_pkg::BLINK_W + 1)'(wmsc_pkg::BLINK_PERIOD))
                      ? wmsc_pkg::BLINK_W'(blink_sum
                            - (wmsc_pkg::BLINK_W + 1)'(wmsc_pkg::BLINK_PERIOD))
                      : blink_sum[wmsc_pkg::BLINK_W-1:0];

    // ------------------------------------------------------------------
    // Fault check. The previous sample is replaced on every tick, faulty
    // or not, so a single glitch can also fault the tick after it.
    // ------------------------------------------------------------------
    assign healthy   = !((s1_sample_reg < sample_min_safe_reg)
                      || (s1_sample_reg > sample_max_safe_reg));
    assign delta     = (s1_sample_reg > prev_sample_reg) ? (s1_sample_reg - prev_sample_reg)
                                                         : (prev_sample_reg - s1_sample_reg);
    assign stable    = (delta <= max_jump_reg);
    assign fault_now = !healthy || !stable || s1_bus_reg;
    assign update    = advance && !fault_now;

    // The filter holds its average while a fault is present.
    wmsc_filter #(
        .WINDOW (WINDOW)
    ) u_filter (
        .clk    (clk),
        .rst_n  (rst_n),
        .update (update),
        .sample (s1_sample_reg),
        .level  (level)
    );

    // ------------------------------------------------------------------
    // Mode choice. A fault forces the wiper off. Otherwise the remote
    // request wins, or the thresholds are tried in order on the fresh
    // average and the first one that the level lies below decides.
    // ------------------------------------------------------------------
    always_comb
    begin
        if (fault_now)
        begin
            mode_now = wmsc_pkg::MODE_STOP;
        end
        else if (s1_remote_reg)
        begin
            mode_now = s1_rmode_reg;
        end
        else if (level < thresh_off_interval_reg)
        begin
            mode_now = wmsc_pkg::MODE_STOP;
        end
        else if (level < thresh_interval_low_reg)
        begin
            mode_now = wmsc_pkg::MODE_INTERVAL;
        end
        else if (level < thresh_low_high_reg)
        begin
            mode_now = wmsc_pkg::MODE_SLOW;
        end
        else
        begin
            mode_now = wmsc_pkg::MODE_FAST;
        end
    end

    // Lamps: a bus fault blinks red and darkens the rest; otherwise blue
    // shows interval, green low and red high.
    always_comb
    begin
        red_now   = 1'b0;
        green_now = 1'b0;
        blue_now  = 1'b0;
        if (s1_bus_reg)
        begin
            red_now = (blink_next < wmsc_pkg::BLINK_ON);
        end
        else
        begin
            case (mode_now)
                wmsc_pkg::MODE_INTERVAL: blue_now  = 1'b1;
                wmsc_pkg::MODE_SLOW:     green_now = 1'b1;
                wmsc_pkg::MODE_FAST:     red_now   = 1'b1;
                default:
                begin
                end
            endcase
        end
    end

    wmsc_sweep u_sweep (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (advance),
        .mode        (mode_now),
        .pause_ms    (interval_pause_ms_reg),
        .status_next (sweep_next)
    );

    // ------------------------------------------------------------------
    // Tick state and result register.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_sample_reg <= '0;
            blink_reg       <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                prev_sample_reg <= s1_sample_reg;
                blink_reg       <= blink_next;
                out_valid_reg   <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            duty_out_reg  <= sweep_next.duty;
            level_out_reg <= level;
            mode_out_reg  <= mode_now;
            phase_out_reg <= sweep_next.phase;
            fault_out_reg <= fault_now;
            red_out_reg   <= red_now;
            green_out_reg <= green_now;
            blue_out_reg  <= blue_now;
        end
    end

    assign out_valid      = out_valid_reg;
    assign servo_duty     = duty_out_reg;
    assign filtered_level = level_out_reg;
    assign wiper_mode     = mode_out_reg;
    assign sweep_phase    = phase_out_reg;
    assign fault          = fault_out_reg;
    assign led_red        = red_out_reg;
    assign led_green      = green_out_reg;
    assign led_blue       = blue_out_reg;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------

    // A result only shows up after an item left the input register.
    a_result_has_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(s1_valid_reg))
        else $error("result appeared without an item in the input register");

    // A faulty tick never reports a running wiper.
    a_fault_means_off: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && fault_out_reg) |-> (mode_out_reg == wmsc_pkg::MODE_STOP))
        else $error("fault reported with a wiper mode other than off");

    // The blink phase stays inside one period.
    a_blink_in_period: assert property (@(posedge clk) disable iff (!rst_n)
        blink_reg < wmsc_pkg::BLINK_W'(wmsc_pkg::BLINK_PERIOD))
        else $error("blink phase left its period");

    // At most one lamp is lit.
    a_one_lamp: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> $onehot0({red_out_reg, green_out_reg, blue_out_reg}))
        else $error("more than one lamp lit");

    // An off mode parks the servo and leaves the sweep idle.
    a_off_parks: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (mode_out_reg == wmsc_pkg::MODE_STOP))
            |-> ((duty_out_reg == wmsc_pkg::DUTY_PARK)
                 && (phase_out_reg == wmsc_pkg::PHASE_IDLE)))
        else $error("servo not parked while the wiper is off");

endmodule
